FILE: src/mm4x4_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mm4x4_pkg
// Types and constants for the fixed-point 4x4 matrix multiplier.
// ----------------------------------------------------------------------------
package mm4x4_pkg;

    // Matrix geometry and number format
    localparam int DIM        = 4;
    localparam int NELEM      = DIM * DIM;
    localparam int FRAC_BITS  = 16;
    localparam int DW         = 32;
    localparam int ELEM_IDX_W = 4;
    localparam int ADDR_W     = $clog2(NELEM);
    localparam int CNT_W      = $clog2(DIM);
    localparam int MUL_W      = 2 * DW;
    localparam int ACC_W      = MUL_W + $clog2(DIM) + 1;

    localparam logic signed [DW-1:0] Q_ONE   = DW'(1 << FRAC_BITS);
    localparam logic signed [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};

    // Store selection codes
    localparam logic SEL_LEFT  = 1'b0;
    localparam logic SEL_RIGHT = 1'b1;

    typedef struct packed {
        logic                         operand_select;
        logic [ELEM_IDX_W-1:0]        element_index;
        logic signed [DW-1:0]         element_value;
        logic                         start_req;
    } elem_item_t;

    typedef struct packed {
        logic [ELEM_IDX_W-1:0]        product_index;
        logic signed [DW-1:0]         product_value;
        logic                         last;
    } prod_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT
    } mm_state_t;

endpackage
`default_nettype wire

FILE: src/matrix4x4_multiply.sv
// A write-only item is stored when it is accepted. A start item enters ST_MAC;
// each of the 16 product elements sums DIM taps on the single shared 32x32
// multiplier, is saturated in ST_DRAIN and is offered in ST_EMIT until the
// receiver takes it. Throughput: one item per cycle while only writing; no
// item is taken during a product. Reset: both stores return to identity,
// write_back clears to 0.
`default_nettype none
// ----------------------------------------------------------------------------
// matrix4x4_multiply
// Q16.16 4x4 matrix product over two element stores, one shared MAC unit,
// optional write-back of the product into the left store.
// ----------------------------------------------------------------------------
module matrix4x4_multiply (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic                   cfg_wdata,
    input  logic                   elem_valid,
    output logic                   elem_stall,
    input  mm4x4_pkg::elem_item_t  elem_item,
    output logic                   prod_valid,
    input  logic                   prod_stall,
    output mm4x4_pkg::prod_item_t  prod_item
);
    import mm4x4_pkg::*;

    mm_state_t state_reg, state_next;

    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] row_reg, row_next;
    logic [CNT_W-1:0] dsel_reg, dsel_next;
    logic             bank_reg, bank_next;
    logic             write_back_reg;
    logic             out_valid_reg, out_valid_next;

    logic signed [MUL_W-1:0] mul_reg, mul_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    prod_item_t              out_reg, out_next;

    // Left store is double-banked: the product goes to the idle bank and
    // write-back is a bank swap at the end of the product.
    logic signed [DW-1:0] left_mem_reg  [2][NELEM];
    logic signed [DW-1:0] right_mem_reg [NELEM];

    logic elem_acc, prod_acc;
    logic mac_en, drain_en;
    logic last_elem;
    logic col_last, row_last, dsel_last;

    logic [ADDR_W-1:0]       l_addr, r_addr, p_addr, w_addr;
    logic signed [DW-1:0]    l_opnd, r_opnd;
    logic signed [ACC_W-1:0] sum, shifted;
    logic signed [DW-1:0]    sat_val;
    logic                    w_in_range;

    // ---------------------------------------------------------------- control
    always_comb
    begin
        elem_stall = 1'b1;
        mac_en     = 1'b0;
        drain_en   = 1'b0;
        unique case (state_reg)
            ST_IDLE:  elem_stall = 1'b0;
            ST_MAC:   mac_en     = 1'b1;
            ST_DRAIN: drain_en   = 1'b1;
            ST_EMIT:  elem_stall = 1'b1;
            default:  elem_stall = 1'b1;
        endcase
    end

    assign elem_acc   = elem_valid && !elem_stall;
    assign prod_acc   = out_valid_reg && !prod_stall;
    assign prod_valid = out_valid_reg;
    assign prod_item  = out_reg;

    assign col_last  = (col_reg == CNT_W'(DIM - 1));
    assign row_last  = (row_reg == CNT_W'(DIM - 1));
    assign dsel_last = (dsel_reg == CNT_W'(DIM - 1));
    assign last_elem = col_last && row_last;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (elem_acc && elem_item.start_req)
                    state_next = ST_MAC;
            end
            ST_MAC:
            begin
                if (dsel_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
                state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (prod_acc)
                    state_next = last_elem ? ST_IDLE : ST_MAC;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // --------------------------------------------------------------- datapath
    assign l_addr = ADDR_W'(DIM * int'(dsel_reg) + int'(row_reg));
    assign r_addr = ADDR_W'(DIM * int'(col_reg) + int'(dsel_reg));
    assign p_addr = ADDR_W'(DIM * int'(col_reg) + int'(row_reg));
    assign w_addr = ADDR_W'(elem_item.element_index);
    assign w_in_range = (int'(elem_item.element_index) < NELEM);

    assign l_opnd = left_mem_reg[bank_reg][l_addr];
    assign r_opnd = right_mem_reg[r_addr];

    assign sum     = acc_reg + ACC_W'(mul_reg);
    assign shifted = sum >>> FRAC_BITS;

    // In range when every bit above the 32-bit result equals its sign bit
    always_comb
    begin
        if ((&shifted[ACC_W-1:DW-1]) || !(|shifted[ACC_W-1:DW-1]))
            sat_val = shifted[DW-1:0];
        else
            sat_val = shifted[ACC_W-1] ? SAT_MIN : SAT_MAX;
    end

    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        dsel_next      = dsel_reg;
        bank_next      = bank_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        mul_next       = MUL_W'(l_opnd) * MUL_W'(r_opnd);
        acc_next       = acc_reg;

        if (elem_acc && elem_item.start_req)
        begin
            col_next  = '0;
            row_next  = '0;
            dsel_next = '0;
        end

        if (mac_en)
        begin
            // first tap of an element restarts the sum
            acc_next  = (dsel_reg == '0) ? '0 : sum;
            dsel_next = dsel_last ? '0 : CNT_W'(dsel_reg + 1'b1);
        end

        if (drain_en)
        begin
            out_valid_next         = 1'b1;
            out_next.product_index = ELEM_IDX_W'(p_addr);
            out_next.product_value = sat_val;
            out_next.last          = last_elem;
        end

        if (prod_acc)
        begin
            out_valid_next = 1'b0;
            if (last_elem)
            begin
                if (write_back_reg)
                    bank_next = !bank_reg;
            end
            else if (row_last)
            begin
                row_next = '0;
                col_next = CNT_W'(col_reg + 1'b1);
            end
            else
                row_next = CNT_W'(row_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            col_reg        <= '0;
            row_reg        <= '0;
            dsel_reg       <= '0;
            bank_reg       <= 1'b0;
            write_back_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            dsel_reg      <= dsel_next;
            bank_reg      <= bank_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                write_back_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_reg <= mul_next;
        acc_reg <= acc_next;
        out_reg <= out_next;
    end

    // Element stores, identity after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NELEM; k++)
            begin
                left_mem_reg[0][k] <= ((k / DIM) == (k % DIM)) ? Q_ONE : '0;
                left_mem_reg[1][k] <= ((k / DIM) == (k % DIM)) ? Q_ONE : '0;
                right_mem_reg[k]   <= ((k / DIM) == (k % DIM)) ? Q_ONE : '0;
            end
        end
        else
        begin
            if (elem_acc && w_in_range)
            begin
                if (elem_item.operand_select == SEL_RIGHT)
                    right_mem_reg[w_addr] <= elem_item.element_value;
                else
                    left_mem_reg[bank_reg][w_addr] <= elem_item.element_value;
            end
            if (drain_en)
                left_mem_reg[!bank_reg][p_addr] <= sat_val;
        end
    end

    // ------------------------------------------------------------- assertions
    a_valid_only_emit: assert property (@(posedge clk) disable iff (!rst_n)
        prod_valid |-> (state_reg == ST_EMIT))
        else $error("result valid outside emit state");

    a_start_enters_mac: assert property (@(posedge clk) disable iff (!rst_n)
        (elem_valid && !elem_stall && elem_item.start_req)
        |=> (state_reg == ST_MAC && dsel_reg == '0 && col_reg == '0 && row_reg == '0))
        else $error("start item did not begin at element zero");

    a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        (prod_valid && !prod_stall && prod_item.last) |=> !elem_stall)
        else $error("input still stalled after final result item");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        prod_valid |-> (prod_item.last ==
                        (prod_item.product_index == ELEM_IDX_W'(NELEM - 1))))
        else $error("last flag does not match final index");

endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Q16.16 4x4 matrix multiplier. A table of
// directed element writes (saturation, truncation, index extremes and
// write-back compounding) is followed by random load-and-multiply
// sequences. Every product item is compared with a local predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import mm4x4_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RAND_ITEMS     = 280;
    localparam int CALM_FROM      = 230;
    localparam int SETTLE_CYC     = 12;
    localparam int TAIL_CYC       = 20;
    localparam int NDIR           = 17;

    typedef struct {
        bit                   wb;
        logic                 sel;
        logic [3:0]           idx;
        logic signed [DW-1:0] val;
        bit                   start;
        bit                   chk;
        logic [3:0]           chk_idx;
        logic signed [DW-1:0] chk_val;
    } stim_row_t;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       cfg_we      = 1'b0;
    logic       cfg_wdata   = 1'b0;
    logic       elem_valid  = 1'b0;
    logic       elem_stall;
    elem_item_t elem_item   = '0;
    logic       prod_valid;
    logic       prod_stall  = 1'b0;
    prod_item_t prod_item;

    // predictor state
    logic signed [DW-1:0] left_m  [NELEM];
    logic signed [DW-1:0] right_m [NELEM];
    bit                   wb_mode = 1'b0;
    prod_item_t           prod_expect_q [$];

    bit         calm        = 1'b0;
    int         stall_left  = 0;
    int         idle_cyc    = 0;
    int         n_err       = 0;
    int         n_items     = 0;
    int         n_products  = 0;
    int         n_results   = 0;
    int         n_sat       = 0;
    int         n_wb_runs   = 0;
    prod_item_t want_item;

    // directed rows; typed expectations only where they are obvious
    stim_row_t dir_tbl [NDIR] = '{
        '{1'b0, SEL_LEFT,  4'd0,  Q_ONE,           1'b1, 1'b1, 4'd5,  Q_ONE},
        '{1'b0, SEL_LEFT,  4'd0,  SAT_MAX,         1'b0, 1'b0, 4'd0,  32'sd0},
        '{1'b0, SEL_RIGHT, 4'd0,  SAT_MAX,         1'b1, 1'b1, 4'd0,  SAT_MAX},
        '{1'b0, SEL_RIGHT, 4'd0,  SAT_MIN,         1'b1, 1'b1, 4'd0,  SAT_MIN},
        '{1'b0, SEL_LEFT,  4'd0,  SAT_MIN,         1'b1, 1'b1, 4'd0,  SAT_MAX},
        '{1'b0, SEL_LEFT,  4'd0,  -32'sd1,         1'b0, 1'b0, 4'd0,  32'sd0},
        '{1'b0, SEL_RIGHT, 4'd0,  32'sd1,          1'b1, 1'b1, 4'd0,  -32'sd1},
        '{1'b0, SEL_LEFT,  4'd0,  32'sh0001_8000,  1'b1, 1'b1, 4'd0,  32'sd1},
        '{1'b0, SEL_LEFT,  4'd15, SAT_MAX,         1'b0, 1'b0, 4'd0,  32'sd0},
        '{1'b0, SEL_RIGHT, 4'd15, -32'sd1,         1'b1, 1'b1, 4'd15, -32'sd32768},
        '{1'b0, SEL_LEFT,  4'd0,  Q_ONE,           1'b0, 1'b0, 4'd0,  32'sd0},
        '{1'b0, SEL_RIGHT, 4'd0,  Q_ONE,           1'b0, 1'b0, 4'd0,  32'sd0},
        '{1'b0, SEL_LEFT,  4'd15, Q_ONE,           1'b0, 1'b0, 4'd0,  32'sd0},
        '{1'b0, SEL_RIGHT, 4'd15, Q_ONE,           1'b1, 1'b1, 4'd1,  32'sd0},
        '{1'b1, SEL_RIGHT, 4'd0,  32'sh0002_0000,  1'b1, 1'b1, 4'd0,  32'sh0002_0000},
        '{1'b1, SEL_RIGHT, 4'd0,  32'sh0002_0000,  1'b1, 1'b1, 4'd0,  32'sh0004_0000},
        '{1'b0, SEL_RIGHT, 4'd0,  32'sh0002_0000,  1'b1, 1'b1, 4'd0,  32'sh0008_0000}
    };

    matrix4x4_multiply i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .elem_valid (elem_valid),
        .elem_stall (elem_stall),
        .elem_item  (elem_item),
        .prod_valid (prod_valid),
        .prod_stall (prod_stall),
        .prod_item  (prod_item)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Write one element, then form L*R if asked; sums are exact, floored, saturated.
    function automatic void matmul_apply(input elem_item_t it);
        logic signed [67:0]   acc;
        logic signed [67:0]   shifted;
        logic signed [DW-1:0] prod [NELEM];
        prod_item_t           r;
        int                   c;
        int                   rw;
        int                   d;
        int                   k;
        if (it.operand_select == SEL_RIGHT)
            right_m[it.element_index] = it.element_value;
        else
            left_m[it.element_index] = it.element_value;
        if (!it.start_req)
            return;
        n_products++;
        if (wb_mode)
            n_wb_runs++;
        for (c = 0; c < DIM; c++)
        begin
            for (rw = 0; rw < DIM; rw++)
            begin
                acc = '0;
                for (d = 0; d < DIM; d++)
                    acc = acc + 68'(left_m[DIM*d + rw]) * 68'(right_m[DIM*c + d]);
                shifted = acc >>> FRAC_BITS;
                if (shifted > SAT_MAX)
                begin
                    prod[DIM*c + rw] = SAT_MAX;
                    n_sat++;
                end
                else if (shifted < SAT_MIN)
                begin
                    prod[DIM*c + rw] = SAT_MIN;
                    n_sat++;
                end
                else
                    prod[DIM*c + rw] = shifted[DW-1:0];
            end
        end
        for (k = 0; k < NELEM; k++)
        begin
            r.product_index = ELEM_IDX_W'(k);
            r.product_value = prod[k];
            r.last          = (k == NELEM - 1);
            prod_expect_q.push_back(r);
        end
        if (wb_mode)
            for (k = 0; k < NELEM; k++)
                left_m[k] = prod[k];
    endfunction

    function automatic logic signed [DW-1:0] rand_elem_val();
        case ($urandom_range(0, 9))
            0:       return SAT_MAX;
            1:       return SAT_MIN;
            2:       return '0;
            3, 4, 5: return $signed(DW'($urandom_range(0, 32'h0008_0000))) - 32'sh0004_0000;
            default: return $signed(DW'($urandom));
        endcase
    endfunction

    task automatic push_elem(input elem_item_t it);
        elem_item  <= it;
        elem_valid <= 1'b1;
        @(posedge clk);
        while (elem_stall)
            @(posedge clk);
        n_items++;
        matmul_apply(it);
    endtask

    task automatic sender_gap();
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            elem_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic drain_products();
        elem_valid <= 1'b0;
        while (prod_expect_q.size() != 0)
            @(posedge clk);
        // settle margin after the last product item
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic set_write_back(input bit v);
        drain_products();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        wb_mode   = v;
    endtask

    // receiver: random stall bursts, none started once calm is set
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            prod_stall <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(0, 11);
            prod_stall <= 1'b1;
        end
        else
            prod_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && prod_valid && !prod_stall)
        begin
            n_results++;
            if (prod_expect_q.size() == 0)
            begin
                $error("unexpected product item: index %0d value %0d",
                       prod_item.product_index, prod_item.product_value);
                n_err++;
            end
            else
            begin
                want_item = prod_expect_q.pop_front();
                if (prod_item.product_index !== want_item.product_index)
                begin
                    $error("product_index: expected %0d, got %0d",
                           want_item.product_index, prod_item.product_index);
                    n_err++;
                end
                if (prod_item.product_value !== want_item.product_value)
                begin
                    $error("product_value: expected %0d, got %0d",
                           want_item.product_value, prod_item.product_value);
                    n_err++;
                end
                if (prod_item.last !== want_item.last)
                begin
                    $error("last: expected %0d, got %0d", want_item.last, prod_item.last);
                    n_err++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((elem_valid && !elem_stall) || (prod_valid && !prod_stall))
                idle_cyc <= 0;
            else
                idle_cyc <= idle_cyc + 1;
            if (idle_cyc >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        elem_item_t it;
        prod_item_t patched;
        int         pos;
        int         rand_cnt;
        int         seq;
        int         kind;
        int         n;
        int         k;
        for (k = 0; k < NELEM; k++)
        begin
            left_m[k]  = (k / DIM == k % DIM) ? Q_ONE : '0;
            right_m[k] = (k / DIM == k % DIM) ? Q_ONE : '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        set_write_back(1'b0);

        foreach (dir_tbl[r])
        begin
            if (dir_tbl[r].wb != wb_mode)
                set_write_back(dir_tbl[r].wb);
            it.operand_select = dir_tbl[r].sel;
            it.element_index  = dir_tbl[r].idx;
            it.element_value  = dir_tbl[r].val;
            it.start_req      = dir_tbl[r].start;
            push_elem(it);
            if (dir_tbl[r].chk)
            begin
                pos = prod_expect_q.size() - NELEM + dir_tbl[r].chk_idx;
                patched = prod_expect_q[pos];
                if (patched.product_value !== dir_tbl[r].chk_val)
                begin
                    $error("row %0d P[%0d]: expected %0d, predictor gives %0d", r,
                           dir_tbl[r].chk_idx, dir_tbl[r].chk_val, patched.product_value);
                    n_err++;
                end
                patched.product_value = dir_tbl[r].chk_val;
                prod_expect_q[pos] = patched;
            end
            sender_gap();
        end

        // mostly loads ending in a start; some lone items and unfinished loads
        rand_cnt = 0;
        seq      = 0;
        while (rand_cnt < RAND_ITEMS)
        begin
            if (!calm && seq % 6 == 5)
                set_write_back(1'($urandom_range(0, 1)));
            else if (!calm && $urandom_range(0, 9) == 0)
                drain_products();
            kind = $urandom_range(0, 9);
            n    = (kind == 0) ? 1 : $urandom_range(1, 12);
            for (k = 0; k < n; k++)
            begin
                it.operand_select = 1'($urandom_range(0, 1));
                it.element_index  = ELEM_IDX_W'($urandom_range(0, NELEM - 1));
                it.element_value  = rand_elem_val();
                if (kind == 0)
                    it.start_req = 1'($urandom_range(0, 1));
                else if (kind == 1)
                    it.start_req = 1'b0;
                else
                    it.start_req = (k == n - 1);
                push_elem(it);
                rand_cnt++;
                calm = (rand_cnt >= CALM_FROM);
                sender_gap();
            end
            seq++;
        end

        elem_valid <= 1'b0;
        while (prod_expect_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYC) @(posedge clk);

        $display("%0d element items, %0d products (%0d with write-back), %0d product items",
                 n_items, n_products, n_wb_runs, n_results);
        $display("%0d saturated product elements expected", n_sat);
        if (n_err == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
